// ----- rtl/core/linear_axis_home_and_move_assert.svh -----
// ----------------------------------------------------------------------------
// Linear axis assertion macros
// Shared concurrent assertion forms for the axis controller.
// ----------------------------------------------------------------------------
`ifndef LINEAR_AXIS_HOME_AND_MOVE_ASSERT_SVH
`define LINEAR_AXIS_HOME_AND_MOVE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LAHM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LAHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lahm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear axis package
// Widths, codes and shared types of the axis homing and positioning block.
// ----------------------------------------------------------------------------
package lahm_pkg;

  localparam int POS_W   = 20;
  localparam int TICK_W  = 16;
  localparam int CHUNK_W = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CAL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd3;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_APPROACH = 2'd1;
  localparam logic [1:0] MODE_BACKOFF  = 2'd2;
  localparam logic [1:0] MODE_MOVING   = 2'd3;

  localparam logic [1:0] SPEED_SLOW   = 2'd0;
  localparam logic [1:0] SPEED_NORMAL = 2'd1;
  localparam logic [1:0] SPEED_FAST   = 2'd2;

  localparam logic [CHUNK_W-1:0] CHUNK_RST  = 8'd10;
  localparam logic [POS_W-1:0]   NEAR_RST   = 20'd1000;
  localparam logic [TICK_W-1:0]  NORMAL_RST = 16'd10;
  localparam logic [TICK_W-1:0]  FAST_RST   = 16'd100;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CAL,
    OP_MOVE,
    OP_RST
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] target;
    logic             hit;
  } item_t;

  typedef struct packed {
    logic               full;
    logic               nonempty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_steps;
    logic [POS_W-1:0]   near_zone;
    logic [TICK_W-1:0]  normal_after_ticks;
    logic [TICK_W-1:0]  fast_after_ticks;
  } cfg_t;

endpackage

// ----- rtl/core/lahm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear axis channel interfaces
// Valid/ready request and result channels of the axis controller.
// ----------------------------------------------------------------------------
interface lahm_in_if import lahm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  target_position;
  logic              endstop_hit;

  modport source (output valid, kind, target_position, endstop_hit, input ready);
  modport sink (input valid, kind, target_position, endstop_hit, output ready);
endinterface

interface lahm_out_if import lahm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHUNK_W-1:0] step_count;
  logic               toward_origin;
  logic [1:0]         speed_mode;
  logic               motor_on;
  logic [3:0]         status_bits;
  logic               move_refused;
  logic               is_ready;

  modport source (output valid, step_count, toward_origin, speed_mode, motor_on,
                  status_bits, move_refused, is_ready, input ready);
  modport sink (input valid, step_count, toward_origin, speed_mode, motor_on,
                status_bits, move_refused, is_ready, output ready);
endinterface

// ----- rtl/core/linear_axis_home_and_move.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear axis home and move controller
// Homes a stepper axis against its endstop and issues step chunks for moves.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_ch    | sink      | valid / ready      | kind, target_position, endstop_hit
//  out_ch   | source    | valid / ready      | step_count .. is_ready
//  cfg_*    | sink      | cfg_we, no stall   | cfg_index, cfg_wdata
//
//  A request taken is written into the queue, popped when the result register is
//  free or being taken, and its result is registered on the pop.
//  The execution stage retires one request per cycle while the result register drains.
//  A two-entry queue sets in_ch.ready; it drops only when the queue is full.
//  Reset is synchronous; configuration returns to its default values.
// ----------------------------------------------------------------------------
`include "linear_axis_home_and_move_assert.svh"

module linear_axis_home_and_move import lahm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lahm_in_if.sink               in_ch,
  lahm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  q_stat_t q_stat;
  logic    push;
  item_t   push_item;
  logic    pop;
  item_t   pop_item;

  logic               drain_go;
  logic               fill_go;
  logic [Q_CNT_W-1:0] cnt_up;
  logic               refused_seen;
  logic               refused_ok;
  logic               ready_seen;
  logic               ready_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunk_steps        <= CHUNK_RST;
      cfg_r.near_zone          <= NEAR_RST;
      cfg_r.normal_after_ticks <= NORMAL_RST;
      cfg_r.fast_after_ticks   <= FAST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHUNK:  cfg_r.chunk_steps        <= cfg_wdata[CHUNK_W-1:0];
        REG_NEAR:   cfg_r.near_zone          <= cfg_wdata[POS_W-1:0];
        REG_NORMAL: cfg_r.normal_after_ticks <= cfg_wdata[TICK_W-1:0];
        REG_FAST:   cfg_r.fast_after_ticks   <= cfg_wdata[TICK_W-1:0];
        default:    cfg_r                    <= cfg_r;
      endcase
    end
  end

  lahm_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  lahm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  lahm_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .pop_item (pop_item),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  assign drain_go     = q_stat.nonempty && (!out_ch.valid || out_ch.ready);
  assign fill_go      = push && !pop;
  assign cnt_up       = q_stat.count + 1'b1;
  assign refused_seen = out_ch.valid && out_ch.move_refused;
  assign refused_ok   = !out_ch.status_bits[1];
  assign ready_seen   = out_ch.valid && out_ch.is_ready;
  assign ready_ok     = !out_ch.status_bits[0] && !out_ch.status_bits[2] &&
                        !out_ch.status_bits[3];

  `LAHM_ASSERT_NEXT(a_drain, clk, rst_n, drain_go, out_ch.valid, "request stalled in queue")
  `LAHM_ASSERT_NEXT(a_fill, clk, rst_n, fill_go, q_stat.count == $past(cnt_up), "queue stuck")
  `LAHM_ASSERT_SAME(a_refused, clk, rst_n, refused_seen, refused_ok, "refused move homed")
  `LAHM_ASSERT_SAME(a_idle, clk, rst_n, ready_seen, ready_ok, "ready flag disagrees with status")

endmodule

// ----- rtl/core/lahm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear axis front end
// Accepts requests and classifies them into queue entries.
// ----------------------------------------------------------------------------
module lahm_front import lahm_pkg::*; (
  lahm_in_if.sink in_ch,
  input  q_stat_t q_stat,
  output logic    push,
  output item_t   push_item
);

  op_t op;

  always_comb begin
    case (in_ch.kind)
      KIND_TICK: op = OP_TICK;
      KIND_CAL:  op = OP_CAL;
      KIND_MOVE: op = OP_MOVE;
      KIND_RST:  op = OP_RST;
      default:   op = OP_TICK;
    endcase
  end

  assign in_ch.ready      = !q_stat.full;
  assign push             = in_ch.valid && !q_stat.full;
  assign push_item.op     = op;
  assign push_item.target = in_ch.target_position;
  assign push_item.hit    = in_ch.endstop_hit;

endmodule

// ----- rtl/core/lahm_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear axis request queue
// Short queue that decouples the front end from the execution stage.
// ----------------------------------------------------------------------------
module lahm_fifo import lahm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   pop_item,
  output q_stat_t q_stat
);

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item        = mem[rd_ptr_r];
  assign q_stat.full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.nonempty = (count_r != '0);
  assign q_stat.count    = count_r;

endmodule

// ----- rtl/core/lahm_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear axis execution stage
// Carries out queued requests on the axis state and registers each result.
// ----------------------------------------------------------------------------
module lahm_exec import lahm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  q_stat_t q_stat,
  input  item_t   pop_item,
  output logic    pop,
  lahm_out_if.source out_ch
);

  logic [1:0]        mode_r, mode_nxt;
  logic              homed_r, homed_nxt;
  logic [POS_W-1:0]  position_r, position_nxt;
  logic [POS_W-1:0]  remaining_r, remaining_nxt;
  logic              toward_r, toward_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [1:0]        speed_r, speed_nxt;
  logic              enabled_r, enabled_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CHUNK_W-1:0] step_r, step_nxt;
  logic               dir_r, dir_nxt;
  logic [3:0]         status_r, status_nxt;
  logic               refused_r, refused_nxt;
  logic               ready_r, ready_nxt;

  logic [CHUNK_W-1:0] chunk;
  logic [POS_W-1:0]   chunk_pos;
  logic [TICK_W-1:0]  tick_inc;
  logic               pos_gt;
  logic [POS_W-1:0]   move_dist;
  logic [POS_W-1:0]   steps_pos;

  assign pop = q_stat.nonempty && (!out_valid_r || out_ch.ready);

  always_comb begin
    chunk     = (cfg.chunk_steps == '0) ? CHUNK_W'(1) : cfg.chunk_steps;
    chunk_pos = {{(POS_W - CHUNK_W){1'b0}}, chunk};
    tick_inc  = (tick_r == '1) ? tick_r : tick_r + 1'b1;
    pos_gt    = position_r > pop_item.target;
    move_dist = pos_gt ? position_r - pop_item.target : pop_item.target - position_r;
    steps_pos = (remaining_r > chunk_pos) ? chunk_pos : remaining_r;

    mode_nxt      = mode_r;
    homed_nxt     = homed_r;
    position_nxt  = position_r;
    remaining_nxt = remaining_r;
    toward_nxt    = toward_r;
    tick_nxt      = tick_r;
    speed_nxt     = speed_r;
    enabled_nxt   = enabled_r;
    step_nxt      = '0;
    dir_nxt       = 1'b0;
    refused_nxt   = 1'b0;

    case (pop_item.op)
      OP_CAL: begin
        mode_nxt    = MODE_APPROACH;
        tick_nxt    = '0;
        enabled_nxt = 1'b1;
        speed_nxt   = SPEED_SLOW;
      end
      OP_MOVE: begin
        if (!homed_r) begin
          refused_nxt = 1'b1;
        end else begin
          toward_nxt    = pos_gt;
          remaining_nxt = move_dist;
          speed_nxt     = SPEED_NORMAL;
          mode_nxt      = MODE_MOVING;
          tick_nxt      = '0;
        end
      end
      OP_RST: begin
        tick_nxt  = '0;
        mode_nxt  = MODE_IDLE;
        homed_nxt = 1'b0;
      end
      default: begin
        case (mode_r)
          MODE_APPROACH: begin
            if (pop_item.hit) begin
              speed_nxt = SPEED_SLOW;
              mode_nxt  = MODE_BACKOFF;
              step_nxt  = CHUNK_W'(1);
              tick_nxt  = '0;
            end else begin
              if (tick_r == cfg.normal_after_ticks) begin
                speed_nxt = SPEED_NORMAL;
              end else if (tick_r == cfg.fast_after_ticks) begin
                speed_nxt = SPEED_FAST;
              end
              step_nxt = chunk;
              dir_nxt  = 1'b1;
              tick_nxt = tick_inc;
            end
          end
          MODE_BACKOFF: begin
            if (pop_item.hit) begin
              step_nxt = CHUNK_W'(1);
            end else begin
              remaining_nxt = '0;
              mode_nxt      = MODE_IDLE;
              homed_nxt     = 1'b1;
              position_nxt  = '0;
            end
            tick_nxt = '0;
          end
          MODE_MOVING: begin
            if (remaining_r == '0) begin
              mode_nxt  = MODE_IDLE;
              homed_nxt = 1'b1;
            end else begin
              if (remaining_r > chunk_pos) begin
                if (remaining_r <= cfg.near_zone && tick_r >= cfg.normal_after_ticks) begin
                  speed_nxt = SPEED_NORMAL;
                end else if (tick_r >= cfg.fast_after_ticks) begin
                  speed_nxt = SPEED_FAST;
                end
              end else begin
                speed_nxt = SPEED_SLOW;
              end
              step_nxt      = steps_pos[CHUNK_W-1:0];
              remaining_nxt = remaining_r - steps_pos;
              position_nxt  = toward_r ? position_r - steps_pos : position_r + steps_pos;
              dir_nxt       = toward_r;
              tick_nxt      = tick_inc;
            end
          end
          default: begin
            tick_nxt = tick_inc;
          end
        endcase
      end
    endcase

    status_nxt = {tick_nxt != '0, mode_nxt == MODE_MOVING, homed_nxt,
                  (mode_nxt == MODE_APPROACH) || (mode_nxt == MODE_BACKOFF)};
    ready_nxt  = (mode_nxt == MODE_IDLE) && (tick_nxt == '0);

    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      homed_r     <= 1'b0;
      position_r  <= '0;
      remaining_r <= '0;
      toward_r    <= 1'b0;
      tick_r      <= '0;
      speed_r     <= SPEED_SLOW;
      enabled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        mode_r      <= mode_nxt;
        homed_r     <= homed_nxt;
        position_r  <= position_nxt;
        remaining_r <= remaining_nxt;
        toward_r    <= toward_nxt;
        tick_r      <= tick_nxt;
        speed_r     <= speed_nxt;
        enabled_r   <= enabled_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      step_r    <= step_nxt;
      dir_r     <= dir_nxt;
      status_r  <= status_nxt;
      refused_r <= refused_nxt;
      ready_r   <= ready_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.step_count    = step_r;
  assign out_ch.toward_origin = dir_r;
  assign out_ch.speed_mode    = speed_r;
  assign out_ch.motor_on      = enabled_r;
  assign out_ch.status_bits   = status_r;
  assign out_ch.move_refused  = refused_r;
  assign out_ch.is_ready      = ready_r;

endmodule

// ----- dv/axis_motion_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis motion checker
// Watches the request, result and register ports of the axis controller. It
// keeps its own copy of the homing and move state, predicts the result of each
// accepted request and compares each delivered result with the oldest one.
// ----------------------------------------------------------------------------
module axis_motion_checker import lahm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lahm_in_if                    in_ch,
  lahm_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           awaited
);

  typedef struct packed {
    logic [CHUNK_W-1:0] step_count;
    logic               toward_origin;
    logic [1:0]         speed_mode;
    logic               motor_on;
    logic [3:0]         status_bits;
    logic               move_refused;
    logic               is_ready;
  } motion_result_t;

  cfg_t              regs;
  logic [1:0]        mode;
  logic              homed;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  remaining;
  logic              heading_home;
  logic [TICK_W-1:0] ticks;
  logic [1:0]        speed;
  logic              enabled;

  motion_result_t    predicted_results[$];
  int unsigned       fail_count = 0;

  task automatic clear_axis();
    regs.chunk_steps        = CHUNK_RST;
    regs.near_zone          = NEAR_RST;
    regs.normal_after_ticks = NORMAL_RST;
    regs.fast_after_ticks   = FAST_RST;
    mode         = MODE_IDLE;
    homed        = 1'b0;
    position     = '0;
    remaining    = '0;
    heading_home = 1'b0;
    ticks        = '0;
    speed        = SPEED_SLOW;
    enabled      = 1'b0;
    predicted_results.delete();
  endtask

  task automatic count_tick();
    if (ticks != '1) begin
      ticks = ticks + 1'b1;
    end
  endtask

  task automatic advance_axis(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] target,
                              input logic hit);
    logic [CHUNK_W-1:0] chunk;
    logic [CHUNK_W-1:0] steps;
    logic               dir;
    logic               refused;
    motion_result_t     res;
    chunk   = (regs.chunk_steps == '0) ? CHUNK_W'(1) : regs.chunk_steps;
    steps   = '0;
    dir     = 1'b0;
    refused = 1'b0;
    case (kind)
      KIND_CAL: begin
        mode    = MODE_APPROACH;
        ticks   = '0;
        enabled = 1'b1;
        speed   = SPEED_SLOW;
      end
      KIND_MOVE: begin
        if (!homed) begin
          refused = 1'b1;
        end else begin
          heading_home = position > target;
          remaining    = heading_home ? position - target : target - position;
          speed        = SPEED_NORMAL;
          mode         = MODE_MOVING;
          ticks        = '0;
        end
      end
      KIND_RST: begin
        ticks = '0;
        mode  = MODE_IDLE;
        homed = 1'b0;
      end
      default: begin
        case (mode)
          MODE_APPROACH: begin
            if (hit) begin
              speed = SPEED_SLOW;
              mode  = MODE_BACKOFF;
              steps = CHUNK_W'(1);
              ticks = '0;
            end else begin
              if (ticks == regs.normal_after_ticks) begin
                speed = SPEED_NORMAL;
              end else if (ticks == regs.fast_after_ticks) begin
                speed = SPEED_FAST;
              end
              steps = chunk;
              dir   = 1'b1;
              count_tick();
            end
          end
          MODE_BACKOFF: begin
            if (hit) begin
              steps = CHUNK_W'(1);
            end else begin
              remaining = '0;
              mode      = MODE_IDLE;
              homed     = 1'b1;
              position  = '0;
            end
            ticks = '0;
          end
          MODE_MOVING: begin
            if (remaining == '0) begin
              mode  = MODE_IDLE;
              homed = 1'b1;
            end else begin
              if (remaining > POS_W'(chunk)) begin
                if (remaining <= regs.near_zone && ticks >= regs.normal_after_ticks) begin
                  speed = SPEED_NORMAL;
                end else if (ticks >= regs.fast_after_ticks) begin
                  speed = SPEED_FAST;
                end
                steps = chunk;
              end else begin
                steps = remaining[CHUNK_W-1:0];
                speed = SPEED_SLOW;
              end
              remaining = remaining - POS_W'(steps);
              position  = heading_home ? position - POS_W'(steps) : position + POS_W'(steps);
              dir       = heading_home;
              count_tick();
            end
          end
          default: begin
            count_tick();
          end
        endcase
      end
    endcase
    res.step_count    = steps;
    res.toward_origin = (steps != '0) ? dir : 1'b0;
    res.speed_mode    = speed;
    res.motor_on      = enabled;
    res.status_bits   = {ticks != '0, mode == MODE_MOVING, homed,
                         mode == MODE_APPROACH || mode == MODE_BACKOFF};
    res.move_refused  = refused;
    res.is_ready      = (mode == MODE_IDLE) && (ticks == '0);
    predicted_results.push_back(res);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    motion_result_t want;
    if (!rst_n) begin
      clear_axis();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result delivered with no request outstanding");
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("step_count", want.step_count, out_ch.step_count);
          check_field("toward_origin", want.toward_origin, out_ch.toward_origin);
          check_field("speed_mode", want.speed_mode, out_ch.speed_mode);
          check_field("motor_on", want.motor_on, out_ch.motor_on);
          check_field("status_bits", want.status_bits, out_ch.status_bits);
          check_field("move_refused", want.move_refused, out_ch.move_refused);
          check_field("is_ready", want.is_ready, out_ch.is_ready);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_axis(in_ch.kind, in_ch.target_position, in_ch.endstop_hit);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CHUNK:  regs.chunk_steps        = cfg_wdata[CHUNK_W-1:0];
          REG_NEAR:   regs.near_zone          = cfg_wdata[POS_W-1:0];
          REG_NORMAL: regs.normal_after_ticks = cfg_wdata[TICK_W-1:0];
          default:    regs.fast_after_ticks   = cfg_wdata[TICK_W-1:0];
        endcase
      end
    end
    mismatches <= fail_count;
    awaited    <= predicted_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis controller testbench
// Drives homing sequences, moves, ticks and resets into the axis controller
// under several register settings and idle patterns; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import lahm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SEGMENT_REQUESTS = 145;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatches;
  int unsigned           awaited;
  int unsigned           idle_pct;
  int unsigned           stall_pct;
  int unsigned           requests_sent;
  int unsigned           quiet_cycles = 0;
  logic [CHUNK_W-1:0]    cur_chunk;

  lahm_in_if  in_ch ();
  lahm_out_if out_ch ();

  linear_axis_home_and_move dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  axis_motion_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] target,
                              input logic hit);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.kind            <= kind;
    in_ch.target_position <= target;
    in_ch.endstop_hit     <= hit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Every request yields a result, so once nothing is awaited the block is idle
  // apart from its short pipeline.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic write_settings(input logic [CHUNK_W-1:0] chunk, input logic [POS_W-1:0] near,
                                input logic [TICK_W-1:0] normal, input logic [TICK_W-1:0] fast);
    cfg_put(REG_CHUNK, CFG_DATA_W'(chunk));
    cfg_put(REG_NEAR, CFG_DATA_W'(near));
    cfg_put(REG_NORMAL, CFG_DATA_W'(normal));
    cfg_put(REG_FAST, CFG_DATA_W'(fast));
    cfg_we    <= 1'b0;
    cur_chunk = chunk;
    @(negedge clk);
  endtask

  task automatic random_settings();
    logic [CHUNK_W-1:0] chunk;
    logic [POS_W-1:0]   near;
    logic [TICK_W-1:0]  normal;
    logic [TICK_W-1:0]  fast;
    case ($urandom_range(3))
      0:       chunk = CHUNK_W'(1);
      1:       chunk = '1;
      default: chunk = CHUNK_W'($urandom_range(1, 40));
    endcase
    case ($urandom_range(3))
      0:       near = '0;
      1:       near = '1;
      default: near = POS_W'($urandom_range(0, 600));
    endcase
    case ($urandom_range(5))
      0:       normal = '0;
      1:       normal = '1;
      default: normal = TICK_W'($urandom_range(0, 20));
    endcase
    case ($urandom_range(5))
      0:       fast = '0;
      1:       fast = '1;
      default: fast = TICK_W'($urandom_range(0, 40));
    endcase
    write_settings(chunk, near, normal, fast);
  endtask

  function automatic logic [POS_W-1:0] pick_target();
    int unsigned span;
    span = ((cur_chunk == '0) ? 1 : cur_chunk) * 30;
    case ($urandom_range(9))
      0:       pick_target = POS_W'($urandom);
      1:       pick_target = '0;
      2:       pick_target = '1;
      default: pick_target = POS_W'($urandom_range(0, span));
    endcase
  endfunction

  // Calibrate, approach, hold on the endstop, then release. A few sequences
  // are cut short before the release.
  task automatic home_axis();
    int unsigned approach;
    int unsigned held;
    approach = $urandom_range(0, 45);
    held     = $urandom_range(1, 4);
    send_request(KIND_CAL, POS_W'($urandom), 1'($urandom));
    repeat (approach) send_request(KIND_TICK, POS_W'($urandom), 1'b0);
    repeat (held) send_request(KIND_TICK, POS_W'($urandom), 1'b1);
    if ($urandom_range(9) != 0) begin
      send_request(KIND_TICK, POS_W'($urandom), 1'b0);
    end
  endtask

  task automatic move_axis();
    int unsigned steps_left;
    steps_left = $urandom_range(0, 35);
    send_request(KIND_MOVE, pick_target(), 1'($urandom));
    repeat (steps_left) send_request(KIND_TICK, POS_W'($urandom), ($urandom_range(7) == 0));
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned goal;
    int unsigned pick;
    goal = requests_sent + quota;
    while (requests_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        home_axis();
      end else if (pick < 75) begin
        move_axis();
      end else if (pick < 90) begin
        send_request(KIND_W'($urandom), POS_W'($urandom), 1'($urandom));
      end else if (pick < 96) begin
        send_request(KIND_RST, POS_W'($urandom), 1'($urandom));
      end else begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_CHUNK;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.kind            = KIND_TICK;
    in_ch.target_position = '0;
    in_ch.endstop_hit     = 1'b0;
    idle_pct              = 0;
    stall_pct             = 0;
    requests_sent         = 0;
    cur_chunk             = CHUNK_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: idle tick, refused move, reset command, a full homing
    // cycle, moves out and back, a zero-length move and a move that cuts
    // into homing.
    send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_MOVE, '1, 1'b0);
    send_request(KIND_RST, '1, 1'b1);
    send_request(KIND_CAL, '0, 1'b0);
    repeat (3) send_request(KIND_TICK, '0, 1'b0);
    repeat (2) send_request(KIND_TICK, '0, 1'b1);
    send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_MOVE, POS_W'(25), 1'b0);
    repeat (4) send_request(KIND_TICK, '1, 1'b0);
    send_request(KIND_MOVE, '0, 1'b1);
    repeat (4) send_request(KIND_TICK, '0, 1'b1);
    send_request(KIND_MOVE, '0, 1'b0);
    send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_CAL, '0, 1'b0);
    send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_MOVE, '1, 1'b0);
    send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_RST, '0, 1'b0);
    send_request(KIND_MOVE, POS_W'(5), 1'b0);
    wait_results_drained();

    // A chunk of zero behaves as a chunk of one.
    write_settings('0, '1, '0, '0);
    send_request(KIND_CAL, '0, 1'b0);
    repeat (2) send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_TICK, '0, 1'b1);
    send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_MOVE, POS_W'(3), 1'b0);
    repeat (4) send_request(KIND_TICK, '0, 1'b0);
    wait_results_drained();

    // A long approach ramps from slow through normal to fast.
    write_settings('1, '0, TICK_W'(30), TICK_W'(45));
    send_request(KIND_CAL, '0, 1'b0);
    repeat (60) send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_TICK, '0, 1'b1);
    send_request(KIND_TICK, '0, 1'b0);
    send_request(KIND_MOVE, '1, 1'b0);
    repeat (5) send_request(KIND_TICK, '0, 1'b0);
    wait_results_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      repeat (2) begin
        wait_results_drained();
        random_settings();
        run_random(SEGMENT_REQUESTS);
      end
    end
    wait_results_drained();
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lahm_pkg.sv
rtl/core/lahm_if.sv
rtl/core/lahm_front.sv
rtl/core/lahm_fifo.sv
rtl/core/lahm_exec.sv
rtl/core/linear_axis_home_and_move.sv
dv/axis_motion_checker.sv
dv/testbench.sv
